### design/dcp_pkg.sv
package dcp_pkg;

	// Default fixed-point precision of the channels and the HSV registers.
	localparam int FRAC_BITS_DEFAULT = 16;

	// Fixed widths of the color index and of the 0.32 hue fraction.
	localparam int IDX_W = 16;
	localparam int HUE_W = 32;

	// Golden-ratio conjugate in 0.32 fixed point.
	localparam logic [HUE_W-1:0] GOLD_Q32 = 32'h9E37_79B9;

	// Reset levels in percent of full scale, rounded to the nearest code.
	localparam int SAT_RESET_PCT  = 95;
	localparam int GRAY_RESET_PCT = 83;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SATURATION = 2'd0,
		CFG_BRIGHTNESS = 2'd1,
		CFG_GRAY_LEVEL = 2'd2
	} cfg_reg_t;

	// The six hue sectors, named by the primary and secondary colors that bound them.
	typedef enum logic [2:0] {
		SEXT_R_Y = 3'd0,
		SEXT_Y_G = 3'd1,
		SEXT_G_C = 3'd2,
		SEXT_C_B = 3'd3,
		SEXT_B_M = 3'd4,
		SEXT_M_R = 3'd5
	} sextant_t;

endpackage

### design/dcp_if.sv
interface dcp_index_if;
	logic                      valid;
	logic                      ready;
	logic [dcp_pkg::IDX_W-1:0] color_index;

	modport source (output valid, output color_index, input ready);
	modport sink   (input valid, input color_index, output ready);
endinterface

interface dcp_rgb_if #(
	parameter int FRAC_BITS = dcp_pkg::FRAC_BITS_DEFAULT
);
	logic               valid;
	logic               ready;
	logic [FRAC_BITS:0] red;
	logic [FRAC_BITS:0] green;
	logic [FRAC_BITS:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### design/dcp_cfg_regs.sv
module dcp_cfg_regs #(
	parameter int FRAC_BITS = dcp_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAC_BITS:0]            cfg_data,
	output logic [FRAC_BITS:0]            sat,
	output logic [FRAC_BITS:0]            val,
	output logic [FRAC_BITS:0]            gray
);

	localparam int CW = FRAC_BITS + 1;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [FRAC_BITS:0] SAT_RST =
		CW'((dcp_pkg::SAT_RESET_PCT * (1 << FRAC_BITS) + 50) / 100);
	localparam logic [FRAC_BITS:0] GRAY_RST =
		CW'((dcp_pkg::GRAY_RESET_PCT * (1 << FRAC_BITS) + 50) / 100);

	logic [FRAC_BITS:0] sat_q;
	logic [FRAC_BITS:0] val_q;
	logic [FRAC_BITS:0] gray_q;
	logic [FRAC_BITS:0] data_clamped;

	// Levels above full scale are stored as full scale, so no reader clamps.
	assign data_clamped = (cfg_data > ONE) ? ONE : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q  <= SAT_RST;
			val_q  <= ONE;
			gray_q <= GRAY_RST;
		end else if (cfg_we) begin
			unique case (dcp_pkg::cfg_reg_t'(cfg_index))
				dcp_pkg::CFG_SATURATION: sat_q  <= data_clamped;
				dcp_pkg::CFG_BRIGHTNESS: val_q  <= data_clamped;
				dcp_pkg::CFG_GRAY_LEVEL: gray_q <= data_clamped;
				default: begin
				end
			endcase
		end
	end

	assign sat  = sat_q;
	assign val  = val_q;
	assign gray = gray_q;

endmodule

### design/distinct_color_palette_hsv_core.sv
// Distinct-color palette core: every color index request returns one RGB triple whose
// channels run from 0 to 2^FRAC_BITS (full scale). Index zero returns the gray level
// register on all three channels; index n > 0 walks the hue circle in golden-ratio
// steps and converts it to RGB with the saturation and brightness registers. The core
// takes one request per clock while the output side is ready, and each result passes
// through the five register stages of the datapath (hue multiply, sector split, the
// three saturation products, the two brightness products, and the output register).
// Each stage holds its own valid bit and fills whenever it is empty or the stage
// after it moves or is empty, so a stall at the output only backs up as far as the
// first empty stage. Registers are written through the plain write port and may
// only be changed while no request is in flight.
module distinct_color_palette_hsv_core #(
	parameter int FRAC_BITS = dcp_pkg::FRAC_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	dcp_index_if.sink                     index_chan,
	dcp_rgb_if.source                     rgb_chan,
	input  logic                          cfg_we,
	input  logic [dcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAC_BITS:0]            cfg_data
);

	localparam int IW = dcp_pkg::IDX_W;
	localparam int HW = dcp_pkg::HUE_W;
	localparam int PW = 2 * FRAC_BITS + 2;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// Register file; stored values are already limited to full scale.
	logic [FRAC_BITS:0] sat;
	logic [FRAC_BITS:0] val;
	logic [FRAC_BITS:0] gray;

	dcp_cfg_regs #(
		.FRAC_BITS(FRAC_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sat      (sat),
		.val      (val),
		.gray     (gray)
	);

	// Stage flow control. A stage loads when it is empty or its contents move on.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v_s5 || rgb_chan.ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign index_chan.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= index_chan.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Stage 1: hue fraction = low 32 bits of (index - 1) times the golden-ratio
	// conjugate. Index zero wraps here, but its hue is never used.
	logic [IW-1:0]    idx_m1;
	logic [IW+HW-1:0] hue_prod;
	logic [HW-1:0]    hue_s1;
	logic             zero_s1;

	assign idx_m1   = index_chan.color_index - IW'(1);
	assign hue_prod = {{HW{1'b0}}, idx_m1} * {{IW{1'b0}}, dcp_pkg::GOLD_Q32};

	always_ff @(posedge clk) begin
		if (rdy1 && index_chan.valid) begin
			hue_s1  <= hue_prod[HW-1:0];
			zero_s1 <= (index_chan.color_index == '0);
		end
	end

	// Stage 2: hue times six, as two shifted copies added. The integer part is the
	// sector and the top FRAC_BITS bits of the remainder are the position in it.
	logic [HW+2:0]          h6;
	logic [2:0]             sext_s2;
	logic [FRAC_BITS-1:0]   f_s2;
	logic                   zero_s2;

	assign h6 = {1'b0, hue_s1, 2'b00} + {2'b00, hue_s1, 1'b0};

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			sext_s2 <= h6[HW+2:HW];
			f_s2    <= h6[HW-1 -: FRAC_BITS];
			zero_s2 <= zero_s1;
		end
	end

	// Stage 3: the saturation products. Each term ends up at most full scale, so
	// the bit above the fraction is enough after the shift.
	logic [FRAC_BITS:0] one_m_f;
	logic [FRAC_BITS:0] one_m_s;
	logic [PW-1:0]      fs_prod;
	logic [PW-1:0]      gs_prod;
	logic [PW-1:0]      p_prod;
	logic [FRAC_BITS:0] qa_s3;
	logic [FRAC_BITS:0] ta_s3;
	logic [FRAC_BITS:0] p_s3;
	logic [2:0]         sext_s3;
	logic               zero_s3;

	assign one_m_f = ONE - {1'b0, f_s2};
	assign one_m_s = ONE - sat;
	assign fs_prod = {{(FRAC_BITS+2){1'b0}}, f_s2} * {{(FRAC_BITS+1){1'b0}}, sat};
	assign gs_prod = {{(FRAC_BITS+1){1'b0}}, one_m_f} * {{(FRAC_BITS+1){1'b0}}, sat};
	assign p_prod  = {{(FRAC_BITS+1){1'b0}}, val} * {{(FRAC_BITS+1){1'b0}}, one_m_s};

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			qa_s3   <= ONE - fs_prod[2*FRAC_BITS:FRAC_BITS];
			ta_s3   <= ONE - gs_prod[2*FRAC_BITS:FRAC_BITS];
			p_s3    <= p_prod[2*FRAC_BITS:FRAC_BITS];
			sext_s3 <= sext_s2;
			zero_s3 <= zero_s2;
		end
	end

	// Stage 4: scale the falling and rising terms by the brightness.
	logic [PW-1:0]      q_prod;
	logic [PW-1:0]      t_prod;
	logic [FRAC_BITS:0] q_s4;
	logic [FRAC_BITS:0] t_s4;
	logic [FRAC_BITS:0] p_s4;
	logic [2:0]         sext_s4;
	logic               zero_s4;

	assign q_prod = {{(FRAC_BITS+1){1'b0}}, val} * {{(FRAC_BITS+1){1'b0}}, qa_s3};
	assign t_prod = {{(FRAC_BITS+1){1'b0}}, val} * {{(FRAC_BITS+1){1'b0}}, ta_s3};

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			q_s4    <= q_prod[2*FRAC_BITS:FRAC_BITS];
			t_s4    <= t_prod[2*FRAC_BITS:FRAC_BITS];
			p_s4    <= p_s3;
			sext_s4 <= sext_s3;
			zero_s4 <= zero_s3;
		end
	end

	// Stage 5: the usual six-way HSV ordering, or the gray level for index zero.
	logic [FRAC_BITS:0] red_d;
	logic [FRAC_BITS:0] green_d;
	logic [FRAC_BITS:0] blue_d;
	logic [FRAC_BITS:0] red_s5;
	logic [FRAC_BITS:0] green_s5;
	logic [FRAC_BITS:0] blue_s5;

	always_comb begin
		if (zero_s4) begin
			red_d   = gray;
			green_d = gray;
			blue_d  = gray;
		end else begin
			case (dcp_pkg::sextant_t'(sext_s4))
				dcp_pkg::SEXT_R_Y: begin
					red_d = val;  green_d = t_s4; blue_d = p_s4;
				end
				dcp_pkg::SEXT_Y_G: begin
					red_d = q_s4; green_d = val;  blue_d = p_s4;
				end
				dcp_pkg::SEXT_G_C: begin
					red_d = p_s4; green_d = val;  blue_d = t_s4;
				end
				dcp_pkg::SEXT_C_B: begin
					red_d = p_s4; green_d = q_s4; blue_d = val;
				end
				dcp_pkg::SEXT_B_M: begin
					red_d = t_s4; green_d = p_s4; blue_d = val;
				end
				default: begin
					red_d = val;  green_d = p_s4; blue_d = q_s4;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			red_s5   <= red_d;
			green_s5 <= green_d;
			blue_s5  <= blue_d;
		end
	end

	assign rgb_chan.valid = v_s5;
	assign rgb_chan.red   = red_s5;
	assign rgb_chan.green = green_s5;
	assign rgb_chan.blue  = blue_s5;

endmodule

### design/dcp_checker.sv
module dcp_checker #(
	parameter int FRAC_BITS = dcp_pkg::FRAC_BITS_DEFAULT
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [FRAC_BITS:0] red,
	input logic [FRAC_BITS:0] green,
	input logic [FRAC_BITS:0] blue
);

	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	// No channel ever leaves the range zero to full scale.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red <= ONE) && (green <= ONE) && (blue <= ONE))
		else $error("channel above full scale");

	// With the output register empty, no stage can be holding up the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output is empty");

	// A request accepted while the output keeps draining shows up once it has passed every stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
		|=> out_valid)
		else $error("result missing after pipeline latency");

	// A stalled result holds still.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("stalled result changed");

endmodule

bind distinct_color_palette_hsv_core dcp_checker #(
	.FRAC_BITS(FRAC_BITS)
) u_dcp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (index_chan.valid),
	.in_ready (index_chan.ready),
	.out_valid(rgb_chan.valid),
	.out_ready(rgb_chan.ready),
	.red      (rgb_chan.red),
	.green    (rgb_chan.green),
	.blue     (rgb_chan.blue)
);
